// ===== rtl/strapdown_ins_mechanization_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the strapdown mechanization unit
// Shared forms of the concurrent checks, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef STRAPDOWN_INS_MECHANIZATION_UNIT_DEFINES_SVH
`define STRAPDOWN_INS_MECHANIZATION_UNIT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SMU_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that, once seen, forces another one at the next clock edge.
`define SMU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/smu_pkg.sv =====
// ----------------------------------------------------------------------------
// smu_pkg
// Widths, constants, control bundles and small index helpers of the unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smu_pkg;

    localparam int AW    = 24;  // accel and rate samples
    localparam int DTW   = 16;  // sample interval
    localparam int GW    = 20;  // gravity register
    localparam int VW    = 32;  // velocity
    localparam int PW    = 48;  // position
    localparam int QW    = 32;  // quaternion and Q30 scalars
    localparam int DVW   = 32;  // velocity increment, 2^-28 m/s
    localparam int DTHW  = 30;  // angle increment, 2^-30 rad
    localparam int DVBW  = 34;  // corrected body increment
    localparam int DVNW  = 38;  // navigation increment accumulator
    localparam int OPW   = 34;  // multiplier operands
    localparam int PRW   = 2 * OPW;
    localparam int ACCW  = 70;  // accumulator
    localparam int DIVW  = 36;  // divider dividend, even
    localparam int DIVSW = 7;   // divider divisor

    localparam logic signed [QW-1:0] Q30_ONE = 32'sh4000_0000;

    localparam logic [DIVSW-1:0] SCULL_DIV = 7'd12;

    // Horner divisors: cosine series first, then the sinc series.
    localparam logic [DIVSW-1:0] HORNER_DIV [8] = '{
        7'd56, 7'd30, 7'd12, 7'd2, 7'd72, 7'd42, 7'd20, 7'd6
    };

    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic clear;
        logic neg;
    } mac_ctl_t;

    typedef struct packed {
        logic             start;
        logic [DIVSW-1:0] divisor;
    } div_req_t;

    function automatic logic [1:0] next1(input logic [1:0] i);
        case (i)
            2'd0:    next1 = 2'd1;
            2'd1:    next1 = 2'd2;
            default: next1 = 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] next2(input logic [1:0] i);
        case (i)
            2'd0:    next2 = 2'd2;
            2'd1:    next2 = 2'd0;
            default: next2 = 2'd1;
        endcase
    endfunction

    // Sign of term t of component i of the quaternion product.
    function automatic logic qn_neg(input logic [1:0] i, input logic [1:0] t);
        case ({i, t})
            4'b0001, 4'b0010, 4'b0011: qn_neg = 1'b1;
            4'b0111:                   qn_neg = 1'b1;
            4'b1001:                   qn_neg = 1'b1;
            4'b1110:                   qn_neg = 1'b1;
            default:                   qn_neg = 1'b0;
        endcase
    endfunction

    function automatic logic signed [QW-1:0] sat_q30(input logic signed [ACCW-1:0] x);
        if (x > ACCW'(Q30_ONE)) begin
            sat_q30 = Q30_ONE;
        end else if (x < -ACCW'(Q30_ONE)) begin
            sat_q30 = -Q30_ONE;
        end else begin
            sat_q30 = x[QW-1:0];
        end
    endfunction

endpackage

// ===== rtl/strapdown_ins_mechanization_unit.sv =====
// ----------------------------------------------------------------------------
// strapdown_ins_mechanization_unit
// Two-sample strapdown mechanization in a north-east-down frame, fixed point.
// ----------------------------------------------------------------------------
// Each accepted IMU word is worked through in full before its navigation word
// is offered, and s_ready stays low for that whole span and for any further wait
// on a result still held in the output register. The span is set by the one
// shared 34x34 multiply-accumulate unit, used in about sixty passes, and by
// seventeen constant divisions (sculling, coning and the two Horner series) in
// the radix-4 divider. The gravity register may be written at any time the unit
// is idle.
`timescale 1ns / 1ps
`include "strapdown_ins_mechanization_unit_defines.svh"

module strapdown_ins_mechanization_unit (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wen,
    input  logic [smu_pkg::GW-1:0]           cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic signed [smu_pkg::AW-1:0]    s_accel_x,
    input  logic signed [smu_pkg::AW-1:0]    s_accel_y,
    input  logic signed [smu_pkg::AW-1:0]    s_accel_z,
    input  logic signed [smu_pkg::AW-1:0]    s_rate_x,
    input  logic signed [smu_pkg::AW-1:0]    s_rate_y,
    input  logic signed [smu_pkg::AW-1:0]    s_rate_z,
    input  logic [smu_pkg::DTW-1:0]          s_interval,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [smu_pkg::PW-1:0]    m_pos_north,
    output logic signed [smu_pkg::PW-1:0]    m_pos_east,
    output logic signed [smu_pkg::PW-1:0]    m_pos_down,
    output logic signed [smu_pkg::VW-1:0]    m_vel_north,
    output logic signed [smu_pkg::VW-1:0]    m_vel_east,
    output logic signed [smu_pkg::VW-1:0]    m_vel_down,
    output logic signed [smu_pkg::QW-1:0]    m_quat_w,
    output logic signed [smu_pkg::QW-1:0]    m_quat_x,
    output logic signed [smu_pkg::QW-1:0]    m_quat_y,
    output logic signed [smu_pkg::QW-1:0]    m_quat_z
);
    import smu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DV, S_DTH, S_ROT, S_SC2, S_SC3, S_CMC, S_CMU, S_GRAV,
        S_VEL, S_POS, S_CON, S_NRM, S_HRN, S_QB, S_QN, S_FIN
    } state_t;

    typedef enum logic [1:0] {PH_MUL, PH_ACC, PH_WB, PH_DIV} phase_t;

    state_t state_reg;
    phase_t phase_reg;
    logic [2:0] idx_reg;
    logic [1:0] jdx_reg;
    logic [1:0] term_reg;
    logic       m_valid_reg;

    logic [GW-1:0]            gravity_reg;
    logic signed [AW-1:0]     acc_in_reg [3];
    logic signed [AW-1:0]     rate_in_reg [3];
    logic [DTW-1:0]           dt_reg;
    logic signed [DVW-1:0]    dv_reg [3];
    logic signed [DTHW-1:0]   dth_reg [3];
    logic signed [DVW-1:0]    pdv_reg [3];
    logic signed [DTHW-1:0]   pdth_reg [3];
    logic signed [DVBW-1:0]   dvb_reg [3];
    logic signed [QW-1:0]     c_reg;
    logic signed [DVNW-1:0]   dvn_reg [3];
    logic signed [VW-1:0]     vel_reg [3];
    logic signed [VW-1:0]     vold_reg;
    logic signed [PW-1:0]     pos_reg [3];
    logic signed [QW-1:0]     phi_reg [3];
    logic signed [QW-1:0]     h_reg;
    logic signed [QW-1:0]     r_reg;
    logic signed [QW-1:0]     sc_reg;
    logic signed [QW-1:0]     qb_reg [4];
    logic signed [QW-1:0]     att_reg [4];
    logic signed [QW-1:0]     anew_reg [4];

    logic signed [PW-1:0]     m_pos_reg [3];
    logic signed [VW-1:0]     m_vel_reg [3];
    logic signed [QW-1:0]     m_quat_reg [4];

    logic [1:0]               ii;
    logic [1:0]               i1;
    logic [1:0]               i2;
    logic [1:0]               kk;
    logic [2:0]               n_terms;
    logic                     last_term;
    logic                     term_neg;
    logic signed [OPW-1:0]    op_a;
    logic signed [OPW-1:0]    op_b;
    logic                     div_step;
    logic [2:0]               last_idx;
    state_t                   follow_state;
    state_t                   adv_state;
    logic [2:0]               adv_idx;
    logic [1:0]               adv_jdx;

    mac_ctl_t                 mac_ctl;
    div_req_t                 div_req;
    logic signed [ACCW-1:0]   acc;
    logic                     div_done;
    logic signed [DIVW-1:0]   div_q;

    logic signed [DVNW-1:0]   dvn_half;
    logic signed [VW:0]       vsum;
    logic signed [VW-1:0]     vel_new;
    logic signed [ACCW-1:0]   pos_rnd;
    logic signed [PW:0]       psum;
    logic signed [PW-1:0]     pos_new;
    logic signed [QW-1:0]     cm_val;
    logic signed [QW-1:0]     att_val;
    logic signed [QW-1:0]     horner_val;

    assign ii = idx_reg[1:0];
    assign i1 = next1(ii);
    assign i2 = next2(ii);
    assign kk = 2'd3 - ii - jdx_reg;

    // Operand selection for the current term of the current step.
    always_comb begin
        op_a     = '0;
        op_b     = '0;
        term_neg = 1'b0;
        n_terms  = 3'd1;
        case (state_reg)
            S_DV: begin
                op_a = OPW'(acc_in_reg[ii]);
                op_b = OPW'(dt_reg);
            end
            S_DTH: begin
                op_a = OPW'(rate_in_reg[ii]);
                op_b = OPW'(dt_reg);
            end
            S_ROT, S_SC2: begin
                n_terms = 3'd2;
                if (term_reg == 2'd0) begin
                    op_a = OPW'((state_reg == S_ROT) ? dth_reg[i1] : pdth_reg[i1]);
                    op_b = OPW'(dv_reg[i2]);
                end else begin
                    op_a     = OPW'((state_reg == S_ROT) ? dth_reg[i2] : pdth_reg[i2]);
                    op_b     = OPW'(dv_reg[i1]);
                    term_neg = 1'b1;
                end
            end
            S_SC3: begin
                n_terms = 3'd2;
                if (term_reg == 2'd0) begin
                    op_a = OPW'(pdv_reg[i1]);
                    op_b = OPW'(dth_reg[i2]);
                end else begin
                    op_a     = OPW'(pdv_reg[i2]);
                    op_b     = OPW'(dth_reg[i1]);
                    term_neg = 1'b1;
                end
            end
            S_CON: begin
                n_terms = 3'd2;
                if (term_reg == 2'd0) begin
                    op_a = OPW'(pdth_reg[i1]);
                    op_b = OPW'(dth_reg[i2]);
                end else begin
                    op_a     = OPW'(pdth_reg[i2]);
                    op_b     = OPW'(dth_reg[i1]);
                    term_neg = 1'b1;
                end
            end
            S_CMC: begin
                if (ii == jdx_reg) begin
                    // Diagonal: w^2 and the own axis add, the other two subtract.
                    n_terms  = 3'd4;
                    op_a     = OPW'(att_reg[term_reg]);
                    op_b     = OPW'(att_reg[term_reg]);
                    term_neg = (term_reg != 2'd0) && (term_reg != ii + 2'd1);
                end else begin
                    n_terms = 3'd2;
                    if (term_reg == 2'd0) begin
                        op_a = OPW'(att_reg[ii + 2'd1]);
                        op_b = OPW'(att_reg[jdx_reg + 2'd1]);
                    end else begin
                        op_a     = OPW'(att_reg[0]);
                        op_b     = OPW'(att_reg[kk + 2'd1]);
                        term_neg = (jdx_reg != i2);
                    end
                end
            end
            S_CMU: begin
                op_a = OPW'(c_reg);
                op_b = OPW'(dvb_reg[jdx_reg]);
            end
            S_GRAV: begin
                op_a = OPW'(gravity_reg);
                op_b = OPW'(dt_reg);
            end
            S_POS: begin
                n_terms = 3'd2;
                op_a    = OPW'((term_reg == 2'd0) ? vel_reg[ii] : vold_reg);
                op_b    = OPW'(dt_reg);
            end
            S_NRM: begin
                n_terms = 3'd3;
                op_a    = OPW'(phi_reg[term_reg]);
                op_b    = OPW'(phi_reg[term_reg]);
            end
            S_HRN: begin
                // Each series restarts from one.
                op_a = OPW'(h_reg);
                op_b = OPW'((ii == 2'd0) ? Q30_ONE : r_reg);
            end
            S_QB: begin
                op_a = OPW'(phi_reg[ii]);
                op_b = OPW'(sc_reg);
            end
            S_QN: begin
                n_terms  = 3'd4;
                op_a     = OPW'(att_reg[term_reg]);
                op_b     = OPW'(qb_reg[ii ^ term_reg]);
                term_neg = qn_neg(ii, term_reg);
            end
            default: begin
                n_terms = 3'd0;
            end
        endcase
    end

    assign last_term = ({1'b0, term_reg} == n_terms - 3'd1);
    assign div_step  = state_reg inside {S_SC2, S_SC3, S_CON, S_HRN};

    assign mac_ctl.mul_en = (phase_reg == PH_MUL) && (n_terms != 3'd0);
    assign mac_ctl.acc_en = (phase_reg == PH_ACC);
    assign mac_ctl.clear  = (term_reg == 2'd0);
    assign mac_ctl.neg    = term_neg;

    assign div_req.start   = (phase_reg == PH_WB) && div_step;
    assign div_req.divisor = (state_reg == S_HRN) ? HORNER_DIV[idx_reg] : SCULL_DIV;

    smu_mac u_mac (
        .aclk (aclk),
        .ctl  (mac_ctl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    smu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .dividend (DIVW'(acc >>> 30)),
        .done     (div_done),
        .quotient (div_q)
    );

    // Step order of the sequencer.
    always_comb begin
        case (state_reg)
            S_HRN:   last_idx = 3'd7;
            S_QN:    last_idx = 3'd3;
            S_GRAV:  last_idx = 3'd0;
            S_NRM:   last_idx = 3'd0;
            default: last_idx = 3'd2;
        endcase
        case (state_reg)
            S_DV:    follow_state = S_DTH;
            S_DTH:   follow_state = S_ROT;
            S_ROT:   follow_state = S_SC2;
            S_SC2:   follow_state = S_SC3;
            S_SC3:   follow_state = S_CMC;
            S_GRAV:  follow_state = S_VEL;
            S_CON:   follow_state = S_NRM;
            S_NRM:   follow_state = S_HRN;
            S_HRN:   follow_state = S_QB;
            S_QB:    follow_state = S_QN;
            default: follow_state = S_FIN;
        endcase
        adv_state = state_reg;
        adv_idx   = idx_reg;
        adv_jdx   = jdx_reg;
        case (state_reg)
            S_CMC: begin
                adv_state = S_CMU;
            end
            S_CMU: begin
                adv_state = S_CMC;
                if (jdx_reg != 2'd2) begin
                    adv_jdx = jdx_reg + 2'd1;
                end else begin
                    adv_jdx = 2'd0;
                    if (ii != 2'd2) begin
                        adv_idx = idx_reg + 3'd1;
                    end else begin
                        adv_idx   = 3'd0;
                        adv_state = S_GRAV;
                    end
                end
            end
            S_VEL: begin
                adv_state = S_POS;
            end
            S_POS: begin
                if (ii != 2'd2) begin
                    adv_idx   = idx_reg + 3'd1;
                    adv_state = S_VEL;
                end else begin
                    adv_idx   = 3'd0;
                    adv_state = S_CON;
                end
            end
            default: begin
                if (idx_reg != last_idx) begin
                    adv_idx = idx_reg + 3'd1;
                end else begin
                    adv_idx   = 3'd0;
                    adv_state = follow_state;
                end
            end
        endcase
    end

    // Write-back arithmetic.
    assign dvn_half = dvn_reg[ii] + DVNW'(2048);
    assign vsum     = (VW+1)'(vel_reg[ii]) + (VW+1)'(dvn_half >>> 12);
    assign vel_new  = (vsum[VW] != vsum[VW-1])
                    ? (vsum[VW] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
                    : vsum[VW-1:0];
    assign pos_rnd  = (acc + ACCW'(1048576)) >>> 21;
    assign psum     = (PW+1)'(pos_reg[ii]) + (PW+1)'(pos_rnd);
    assign pos_new  = (psum[PW] != psum[PW-1])
                    ? (psum[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}})
                    : psum[PW-1:0];
    // Off-diagonal sums carry a factor of two, folded into a shift by 29.
    assign cm_val     = sat_q30((ii == jdx_reg) ? (acc >>> 30) : (acc >>> 29));
    assign att_val    = sat_q30((acc + ACCW'(536870912)) >>> 30);
    assign horner_val = Q30_ONE - QW'(div_q);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_MUL;
            idx_reg     <= '0;
            jdx_reg     <= '0;
            term_reg    <= '0;
            m_valid_reg <= 1'b0;
            gravity_reg <= GW'(642689);
            for (int k = 0; k < 3; k++) begin
                vel_reg[k]  <= '0;
                pos_reg[k]  <= '0;
                pdv_reg[k]  <= '0;
                pdth_reg[k] <= '0;
            end
            att_reg[0] <= Q30_ONE;
            att_reg[1] <= '0;
            att_reg[2] <= '0;
            att_reg[3] <= '0;
        end else begin
            if (cfg_wen) begin
                gravity_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        acc_in_reg[0]  <= s_accel_x;
                        acc_in_reg[1]  <= s_accel_y;
                        acc_in_reg[2]  <= s_accel_z;
                        rate_in_reg[0] <= s_rate_x;
                        rate_in_reg[1] <= s_rate_y;
                        rate_in_reg[2] <= s_rate_z;
                        dt_reg         <= s_interval;
                        state_reg      <= S_DV;
                        phase_reg      <= PH_MUL;
                        idx_reg        <= '0;
                        jdx_reg        <= '0;
                        term_reg       <= '0;
                    end
                end
                S_FIN: begin
                    // Hold the finished word until the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        for (int k = 0; k < 3; k++) begin
                            m_pos_reg[k] <= pos_reg[k];
                            m_vel_reg[k] <= vel_reg[k];
                            pdv_reg[k]   <= dv_reg[k];
                            pdth_reg[k]  <= dth_reg[k];
                        end
                        for (int k = 0; k < 4; k++) begin
                            m_quat_reg[k] <= anew_reg[k];
                            att_reg[k]    <= anew_reg[k];
                        end
                        m_valid_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: begin
                    case (phase_reg)
                        PH_MUL: begin
                            phase_reg <= (n_terms == 3'd0) ? PH_WB : PH_ACC;
                        end
                        PH_ACC: begin
                            if (last_term) begin
                                phase_reg <= PH_WB;
                            end else begin
                                term_reg  <= term_reg + 2'd1;
                                phase_reg <= PH_MUL;
                            end
                        end
                        PH_WB: begin
                            if (div_step) begin
                                phase_reg <= PH_DIV;
                            end else begin
                                case (state_reg)
                                    S_DV:   dv_reg[ii]  <= DVW'(acc >>> 8);
                                    S_DTH:  dth_reg[ii] <= DTHW'(acc >>> 10);
                                    S_ROT:  dvb_reg[ii] <= DVBW'(dv_reg[ii]) + DVBW'(acc >>> 31);
                                    S_CMC:  c_reg       <= cm_val;
                                    S_CMU: begin
                                        dvn_reg[ii] <= ((jdx_reg == 2'd0) ? '0 : dvn_reg[ii])
                                                     + DVNW'(acc >>> 30);
                                    end
                                    S_GRAV: dvn_reg[2] <= dvn_reg[2] + DVNW'(acc >>> 8);
                                    S_VEL: begin
                                        vold_reg    <= vel_reg[ii];
                                        vel_reg[ii] <= vel_new;
                                    end
                                    S_POS:  pos_reg[ii] <= pos_new;
                                    S_NRM:  h_reg       <= QW'(acc >>> 32);
                                    S_QB:   qb_reg[ii + 2'd1] <= QW'(acc >>> 31);
                                    S_QN:   anew_reg[ii] <= att_val;
                                    default: ;
                                endcase
                                state_reg <= adv_state;
                                idx_reg   <= adv_idx;
                                jdx_reg   <= adv_jdx;
                                term_reg  <= '0;
                                phase_reg <= PH_MUL;
                            end
                        end
                        PH_DIV: begin
                            if (div_done) begin
                                case (state_reg)
                                    S_SC2, S_SC3: dvb_reg[ii] <= dvb_reg[ii] + DVBW'(div_q);
                                    S_CON: phi_reg[ii] <= QW'(dth_reg[ii]) + QW'(div_q);
                                    S_HRN: begin
                                        r_reg <= horner_val;
                                        if (idx_reg == 3'd3) begin
                                            qb_reg[0] <= horner_val;
                                        end
                                        if (idx_reg == 3'd7) begin
                                            sc_reg <= horner_val;
                                        end
                                    end
                                    default: ;
                                endcase
                                state_reg <= adv_state;
                                idx_reg   <= adv_idx;
                                jdx_reg   <= adv_jdx;
                                term_reg  <= '0;
                                phase_reg <= PH_MUL;
                            end
                        end
                        default: phase_reg <= PH_MUL;
                    endcase
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == S_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_pos_north = m_pos_reg[0];
    assign m_pos_east  = m_pos_reg[1];
    assign m_pos_down  = m_pos_reg[2];
    assign m_vel_north = m_vel_reg[0];
    assign m_vel_east  = m_vel_reg[1];
    assign m_vel_down  = m_vel_reg[2];
    assign m_quat_w    = m_quat_reg[0];
    assign m_quat_x    = m_quat_reg[1];
    assign m_quat_y    = m_quat_reg[2];
    assign m_quat_z    = m_quat_reg[3];

    `SMU_ASSERT_NEXT(a_accept_starts, s_valid && s_ready, state_reg == S_DV, "accepted word did not start")
    `SMU_ASSERT_ALWAYS(a_div_awaited, !div_done || (phase_reg == PH_DIV), "divider finished unwatched")
    `SMU_ASSERT_NEXT(a_fin_holds, (state_reg == S_FIN) && m_valid_reg && !m_ready, state_reg == S_FIN, "result overwrote a waiting word")
    `SMU_ASSERT_ALWAYS(a_valid_from_fin, !$rose(m_valid_reg) || ($past(state_reg) == S_FIN), "result raised outside the final step")

endmodule

// ===== rtl/smu_mac.sv =====
// ----------------------------------------------------------------------------
// smu_mac
// Shared signed multiplier with a product register and an accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smu_mac (
    input  logic                               aclk,
    input  smu_pkg::mac_ctl_t                  ctl,
    input  logic signed [smu_pkg::OPW-1:0]     op_a,
    input  logic signed [smu_pkg::OPW-1:0]     op_b,
    output logic signed [smu_pkg::ACCW-1:0]    acc
);
    import smu_pkg::*;

    logic signed [PRW-1:0]  prod_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic signed [ACCW-1:0] base;
    logic signed [ACCW-1:0] prod_ext;

    assign base     = ctl.clear ? '0 : acc_reg;
    assign prod_ext = ACCW'(prod_reg);

    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (ctl.acc_en) begin
            acc_reg <= ctl.neg ? (base - prod_ext) : (base + prod_ext);
        end
    end

    assign acc = acc_reg;

endmodule

// ===== rtl/smu_div.sv =====
// ----------------------------------------------------------------------------
// smu_div
// Radix-4 restoring divider with floor rounding for a small constant divisor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smu_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  smu_pkg::div_req_t                  req,
    input  logic signed [smu_pkg::DIVW-1:0]    dividend,
    output logic                               done,
    output logic signed [smu_pkg::DIVW-1:0]    quotient
);
    import smu_pkg::*;

    localparam int ITER = DIVW / 2;
    localparam int CW   = $clog2(ITER + 1);

    logic [CW-1:0]    cnt_reg;
    logic [DIVW-1:0]  work_reg;
    logic [DIVSW-1:0] rem_reg;
    logic [DIVSW-1:0] dsr_reg;
    logic             neg_reg;
    logic             done_reg;

    logic [DIVSW:0]   r1;
    logic [DIVSW:0]   r2;
    logic [DIVSW-1:0] r1s;
    logic [DIVSW-1:0] r2s;
    logic             q1;
    logic             q2;

    // Two quotient bits per cycle. A negative dividend is handled as the
    // one's complement, which gives floor rounding for a positive divisor.
    always_comb begin
        r1  = {rem_reg, work_reg[DIVW-1]};
        q1  = (r1 >= {1'b0, dsr_reg});
        r1s = q1 ? DIVSW'(r1 - {1'b0, dsr_reg}) : r1[DIVSW-1:0];
        r2  = {r1s, work_reg[DIVW-2]};
        q2  = (r2 >= {1'b0, dsr_reg});
        r2s = q2 ? DIVSW'(r2 - {1'b0, dsr_reg}) : r2[DIVSW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                cnt_reg  <= CW'(ITER);
                neg_reg  <= dividend[DIVW-1];
                work_reg <= dividend[DIVW-1] ? ~dividend : dividend;
                rem_reg  <= '0;
                dsr_reg  <= req.divisor;
            end else if (cnt_reg != '0) begin
                cnt_reg  <= cnt_reg - CW'(1);
                work_reg <= {work_reg[DIVW-3:0], q1, q2};
                rem_reg  <= r2s;
                if (cnt_reg == CW'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? ~work_reg : work_reg;

endmodule
